// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL; bam_ctrl.sv is the file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define BAM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Trigger in one cycle implies the consequence in the next.
`define BAM_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bam_pkg.sv =====
`timescale 1ns / 1ps

package bam_pkg;

  typedef enum logic [3:0] {
    CMD_AND = 4'd0,
    CMD_OR  = 4'd1,
    CMD_XOR = 4'd2,
    CMD_NOT = 4'd3,
    CMD_ADD = 4'd4,
    CMD_SUB = 4'd5,
    CMD_MUL = 4'd6,
    CMD_DIV = 4'd7,
    CMD_MOD = 4'd8,
    CMD_SHL = 4'd9,
    CMD_SHR = 4'd10
  } cmd_e;

  localparam int unsigned CmdWidth = 4;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture a new beat
    logic step;      // one multiply or divide iteration
    logic out_load;  // move the result into the output register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic iter_op;   // incoming command needs the iterative unit
  } dp_status_t;

endpackage

// ===== hdl/bam_ctrl.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bam_ctrl #(
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  input  bam_pkg::dp_status_t    status_i,
  output bam_pkg::ctrl_cmd_t     cmd_o
);

  localparam int unsigned CntWidth = $clog2(DATA_WIDTH);
  localparam logic [CntWidth-1:0] LastStep = CntWidth'(DATA_WIDTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                out_free;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign out_free   = !out_valid_q || m_tready_i;
  assign m_tvalid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    out_valid_d    = out_valid_q;
    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = status_i.iter_op ? ST_BUSY : ST_DONE;
        end
      end
      ST_BUSY: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register drains
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `BAM_ASSERT(a_no_overwrite, clk_i, rst_ni, cmd_o.out_load |-> (!out_valid_q || m_tready_i), "output beat overwritten before taken")
  `BAM_ASSERT_NEXT(a_iter_len, clk_i, rst_ni, (state_q == ST_BUSY) && (cnt_q == LastStep), state_q == ST_DONE, "iteration count overran")
  `BAM_ASSERT_NEXT(a_out_set, clk_i, rst_ni, cmd_o.out_load, out_valid_q, "result loaded without valid")
  `BAM_ASSERT(a_busy_no_accept, clk_i, rst_ni, (state_q != ST_IDLE) |-> !accept, "beat accepted while busy")

endmodule

// ===== hdl/bam_datapath.sv =====
`timescale 1ns / 1ps

module bam_datapath #(
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic                             clk_i,
  input  logic [bam_pkg::CmdWidth-1:0]     in_cmd_i,
  input  logic [DATA_WIDTH-1:0]            in_a_i,
  input  logic [DATA_WIDTH-1:0]            in_b_i,
  input  bam_pkg::ctrl_cmd_t               cmd_i,
  output bam_pkg::dp_status_t              status_o,
  output logic [DATA_WIDTH-1:0]            result_o
);

  localparam logic [DATA_WIDTH-1:0] WidthVal = DATA_WIDTH'(DATA_WIDTH);

  logic [bam_pkg::CmdWidth-1:0] cmd_q;
  logic [DATA_WIDTH-1:0]        a_q, b_q;
  logic [DATA_WIDTH-1:0]        acc_q, acc_d;  // product or remainder
  logic [DATA_WIDTH-1:0]        x_q, x_d;      // multiplicand or dividend
  logic [DATA_WIDTH-1:0]        y_q, y_d;      // multiplier or quotient
  logic [DATA_WIDTH-1:0]        res_q, res_mux;
  logic [DATA_WIDTH-1:0]        rem_sh;
  logic                         is_div;

  assign status_o.iter_op = in_cmd_i inside {bam_pkg::CMD_MUL, bam_pkg::CMD_DIV,
                                             bam_pkg::CMD_MOD};
  assign is_div = (cmd_q == bam_pkg::CMD_DIV) || (cmd_q == bam_pkg::CMD_MOD);
  assign rem_sh = {acc_q[DATA_WIDTH-2:0], x_q[DATA_WIDTH-1]};

  always_comb begin
    acc_d = acc_q;
    x_d   = x_q;
    y_d   = y_q;
    if (is_div) begin
      // restoring step: shift in the next dividend bit, subtract if it fits
      x_d = {x_q[DATA_WIDTH-2:0], 1'b0};
      if (acc_q[DATA_WIDTH-1] || (rem_sh >= b_q)) begin
        acc_d = rem_sh - b_q;
        y_d   = {y_q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        acc_d = rem_sh;
        y_d   = {y_q[DATA_WIDTH-2:0], 1'b0};
      end
    end else begin
      acc_d = acc_q + (y_q[0] ? x_q : '0);
      x_d   = {x_q[DATA_WIDTH-2:0], 1'b0};
      y_d   = {1'b0, y_q[DATA_WIDTH-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_cmd_i;
      a_q   <= in_a_i;
      b_q   <= in_b_i;
      acc_q <= '0;
      x_q   <= in_a_i;
      y_q   <= (in_cmd_i == bam_pkg::CMD_MUL) ? in_b_i : '0;
    end else if (cmd_i.step) begin
      acc_q <= acc_d;
      x_q   <= x_d;
      y_q   <= y_d;
    end
    if (cmd_i.out_load) begin
      res_q <= res_mux;
    end
  end

  always_comb begin
    case (cmd_q)
      bam_pkg::CMD_AND: res_mux = a_q & b_q;
      bam_pkg::CMD_OR:  res_mux = a_q | b_q;
      bam_pkg::CMD_XOR: res_mux = a_q ^ b_q;
      bam_pkg::CMD_NOT: res_mux = ~a_q;
      bam_pkg::CMD_ADD: res_mux = a_q + b_q;
      bam_pkg::CMD_SUB: res_mux = a_q - b_q;
      bam_pkg::CMD_MUL: res_mux = acc_q;
      bam_pkg::CMD_DIV: res_mux = y_q;
      bam_pkg::CMD_MOD: res_mux = acc_q;
      bam_pkg::CMD_SHL: res_mux = (b_q < WidthVal) ? (a_q << b_q) : '0;
      bam_pkg::CMD_SHR: res_mux = (b_q < WidthVal) ? (a_q >> b_q) : '0;
      default:          res_mux = '0;
    endcase
  end

  assign result_o = res_q;

endmodule

// ===== hdl/byte_alu_with_mul_div.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Beat contents (lowest bits first)
// s_*       in         command[3:0], operand_a[W-1:0], operand_b[W-1:0]
// m_*       out        result[W-1:0]
//
// Logic, add, subtract and shifts: accept, then the result state loads the output.
// Multiply, divide and modulo: accept, W iterations of the shift-add or
// restoring step unit (one bit per cycle), then the result state loads the output.
// One beat in flight; s_tready is high only while the controller is idle.
// A finished result sits in the output register while the next beat is taken.
// Reset is asynchronous, active low, and clears control state only.
module byte_alu_with_mul_div #(
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  // command[3:0], operand_a, operand_b, zero pad
  input  logic [((bam_pkg::CmdWidth + 2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata_i,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  // result, zero pad
  output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] m_tdata_o
);

  localparam int unsigned OutBits = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int unsigned ALo     = bam_pkg::CmdWidth;
  localparam int unsigned BLo     = bam_pkg::CmdWidth + DATA_WIDTH;

  bam_pkg::ctrl_cmd_t    ctrl_cmd;
  bam_pkg::dp_status_t   dp_status;
  logic [DATA_WIDTH-1:0] result;

  bam_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  bam_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .in_cmd_i (s_tdata_i[bam_pkg::CmdWidth-1:0]),
    .in_a_i   (s_tdata_i[ALo +: DATA_WIDTH]),
    .in_b_i   (s_tdata_i[BLo +: DATA_WIDTH]),
    .cmd_i    (ctrl_cmd),
    .status_o (dp_status),
    .result_o (result)
  );

  assign m_tdata_o = OutBits'(result);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DataW   = 8;
  localparam int unsigned InBits  = ((bam_pkg::CmdWidth + 2 * DataW + 7) / 8) * 8;
  localparam int unsigned OutBits = ((DataW + 7) / 8) * 8;
  localparam int unsigned DrainCycles = 3 * (DataW + 2);
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned LongHold    = 300;
  localparam logic [3:0]  CmdUnusedLo = 4'd11;
  localparam logic [3:0]  CmdUnusedHi = 4'd15;

  typedef enum {TX_BURSTY, TX_STREAM} tx_mode_e;
  typedef enum {RX_ALWAYS, RX_RANDOM, RX_ROTATE} rx_mode_e;

  typedef struct {
    logic [3:0]       cmd;
    logic [DataW-1:0] op_a;
    logic [DataW-1:0] op_b;
    logic [DataW-1:0] result;
  } alu_expect_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_tvalid_i;
  logic               s_tready_o;
  logic [InBits-1:0]  s_tdata_i;  // command[3:0], operand_a, operand_b, zero pad
  logic               m_tvalid_o;
  logic               m_tready_i;
  logic [OutBits-1:0] m_tdata_o;  // result

  alu_expect_t pending_results[$];
  int          mismatch_count = 0;
  tx_mode_e    tx_mode = TX_BURSTY;
  rx_mode_e    rx_mode = RX_ALWAYS;
  int          rx_stall_pct = 30;
  int          hold_request = 0;
  int          burst_left = 0;

  byte_alu_with_mul_div #(
    .DATA_WIDTH(DataW)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [DataW-1:0] alu_result(logic [3:0] cmd, logic [DataW-1:0] a,
                                                  logic [DataW-1:0] b);
    logic [DataW-1:0]   quo;
    logic [DataW-1:0]   rem;
    logic               top;
    logic [2*DataW-1:0] prod;
    quo = '0;
    rem = '0;
    // restoring division, dividend MSB first; a set top bit always subtracts
    for (int i = DataW - 1; i >= 0; i--) begin
      top = rem[DataW-1];
      rem = {rem[DataW-2:0], a[i]};
      quo = quo << 1;
      if (top || rem >= b) begin
        rem = rem - b;
        quo[0] = 1'b1;
      end
    end
    prod = a * b;
    case (cmd)
      bam_pkg::CMD_AND: return a & b;
      bam_pkg::CMD_OR:  return a | b;
      bam_pkg::CMD_XOR: return a ^ b;
      bam_pkg::CMD_NOT: return ~a;
      bam_pkg::CMD_ADD: return a + b;
      bam_pkg::CMD_SUB: return a - b;
      bam_pkg::CMD_MUL: return prod[DataW-1:0];
      bam_pkg::CMD_DIV: return quo;
      bam_pkg::CMD_MOD: return rem;
      bam_pkg::CMD_SHL: return (b < DataW) ? DataW'(a << b) : '0;
      bam_pkg::CMD_SHR: return (b < DataW) ? DataW'(a >> b) : '0;
      default:          return '0;
    endcase
  endfunction

  task automatic note_failure(string what, alu_expect_t exp, logic [DataW-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t mismatch (%s): cmd=%0d a=%0d b=%0d expected=%0d actual=%0d",
               $realtime, what, exp.cmd, exp.op_a, exp.op_b, exp.result, got);
    end
  endtask

  // Drive one beat; returns at the edge where it was accepted.
  task automatic send_alu_beat(logic [3:0] cmd, logic [DataW-1:0] a, logic [DataW-1:0] b);
    int          gap;
    alu_expect_t exp;
    gap = 0;
    if (tx_mode == TX_BURSTY) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      burst_left--;
    end
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= InBits'({b, a, cmd});
    do @(posedge clk_i); while (!s_tready_o);
    exp.cmd    = cmd;
    exp.op_a   = a;
    exp.op_b   = b;
    exp.result = alu_result(cmd, a, b);
    pending_results.push_back(exp);
  endtask

  // Drop valid so the last beat is not offered again, then wait for all results.
  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_operand();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return DataW'(1);
      3:       return 8'h80;
      4:       return 8'h7f;
      default: return DataW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [3:0] pick_command();
    if ($urandom_range(0, 49) == 0) return 4'($urandom_range(CmdUnusedLo, CmdUnusedHi));
    return 4'($urandom_range(bam_pkg::CMD_AND, bam_pkg::CMD_SHR));
  endfunction

  task automatic send_random_beats(int count);
    logic [3:0]       cmd;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    for (int i = 0; i < count; i++) begin
      cmd = pick_command();
      a   = pick_operand();
      b   = pick_operand();
      if (cmd == bam_pkg::CMD_SHL || cmd == bam_pkg::CMD_SHR) begin
        if ($urandom_range(0, 3) != 0) b = DataW'($urandom_range(0, DataW + 1));
      end else if ((cmd == bam_pkg::CMD_DIV || cmd == bam_pkg::CMD_MOD) &&
                   $urandom_range(0, 7) == 0) begin
        b = '0;
      end else if (cmd == bam_pkg::CMD_MUL && $urandom_range(0, 3) == 0) begin
        b = DataW'($urandom_range(0, 15));
      end
      send_alu_beat(cmd, a, b);
    end
  endtask

  task automatic test_directed();
    send_alu_beat(bam_pkg::CMD_AND, 8'hff, 8'h5a);
    send_alu_beat(bam_pkg::CMD_OR,  8'h00, 8'ha5);
    send_alu_beat(bam_pkg::CMD_XOR, 8'hff, 8'h0f);
    send_alu_beat(bam_pkg::CMD_NOT, 8'h3c, 8'hff);
    send_alu_beat(bam_pkg::CMD_NOT, 8'h00, 8'h12);
    send_alu_beat(bam_pkg::CMD_ADD, 8'hff, 8'h01);
    send_alu_beat(bam_pkg::CMD_ADD, 8'hff, 8'hff);
    send_alu_beat(bam_pkg::CMD_SUB, 8'h00, 8'h01);
    send_alu_beat(bam_pkg::CMD_SUB, 8'h80, 8'h80);
    send_alu_beat(bam_pkg::CMD_MUL, 8'hff, 8'hff);
    send_alu_beat(bam_pkg::CMD_MUL, 8'h10, 8'h10);
    send_alu_beat(bam_pkg::CMD_DIV, 8'hff, 8'h01);
    send_alu_beat(bam_pkg::CMD_DIV, 8'hc8, 8'h00);
    send_alu_beat(bam_pkg::CMD_DIV, 8'hfe, 8'hff);
    send_alu_beat(bam_pkg::CMD_MOD, 8'hc8, 8'h00);
    send_alu_beat(bam_pkg::CMD_MOD, 8'hff, 8'h81);
    send_alu_beat(bam_pkg::CMD_SHL, 8'hff, 8'h07);
    send_alu_beat(bam_pkg::CMD_SHL, 8'hff, 8'h08);
    send_alu_beat(bam_pkg::CMD_SHL, 8'h01, 8'hff);
    send_alu_beat(bam_pkg::CMD_SHR, 8'h80, 8'h07);
    send_alu_beat(bam_pkg::CMD_SHR, 8'hff, 8'h08);
    send_alu_beat(bam_pkg::CMD_SHR, 8'hff, 8'h00);
    send_alu_beat(CmdUnusedLo, 8'hff, 8'hff);
    send_alu_beat(CmdUnusedHi, 8'hff, 8'hff);
  endtask

  task automatic test_random_mix();
    tx_mode = TX_BURSTY;
    rx_mode = RX_RANDOM;
    rx_stall_pct = 30;
    send_random_beats(600);
    rx_mode = RX_ROTATE;
    send_random_beats(550);
  endtask

  // Hold the output long enough that the block backs up and stalls its input.
  task automatic test_output_backpressure();
    tx_mode = TX_STREAM;
    rx_mode = RX_ALWAYS;
    hold_request = LongHold;
    send_random_beats(30);
  endtask

  task automatic test_drain_pause();
    tx_mode = TX_BURSTY;
    rx_mode = RX_RANDOM;
    send_random_beats(20);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    send_random_beats(20);
  endtask

  task automatic test_full_rate();
    tx_mode = TX_STREAM;
    rx_mode = RX_ALWAYS;
    send_random_beats(200);
  endtask

  task automatic test_heavy_stall();
    tx_mode = TX_BURSTY;
    rx_mode = RX_RANDOM;
    rx_stall_pct = 75;
    send_random_beats(200);
  endtask

  // Receiver: always ready, random stalls or a rotating ready pattern, plus one-off long holds.
  initial m_tready_i = 1'b0;
  always @(posedge clk_i) begin
    static int          hold_left = 0;
    static logic [10:0] rx_pattern = 11'b110_1011_0111;
    rx_pattern = {rx_pattern[0], rx_pattern[10:1]};
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM: m_tready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
        RX_ROTATE: m_tready_i <= rx_pattern[0];
        default:   m_tready_i <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    alu_expect_t exp;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_results.size() == 0) begin
        exp = '{cmd: '0, op_a: '0, op_b: '0, result: '0};
        note_failure("no result expected", exp, m_tdata_o[DataW-1:0]);
      end else begin
        exp = pending_results.pop_front();
        if (m_tdata_o[DataW-1:0] !== exp.result) begin
          note_failure("result", exp, m_tdata_o[DataW-1:0]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    static int quiet_cycles = 0;
    if (!rst_ni || (s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("timeout: no beat moved for %0d cycles", StallLimit);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    s_tvalid_i = 1'b0;
    s_tdata_i  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix();
    test_output_backpressure();
    test_drain_pause();
    test_full_rate();
    test_heavy_stall();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
